// ----- src/aabb_pkg.sv -----
`timescale 1ns / 1ps
// aabb_pkg: sizes, codes and shared types of the box collision table.
// No dependencies; used by every module of the block.
package aabb_pkg;

    localparam int MAX_BOXES    = 32;
    localparam int RESULT_LIMIT = 32;

    localparam int SLOT_W  = 5;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int COUNT_W = 6;

    localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int SLOT_CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_SET    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_POINT  = 2'd2,
        ACT_BOX    = 2'd3
    } act_t;

    // Classified request: far corners already saturated, equal to the
    // near corner for a point query.
    typedef struct packed {
        act_t                      act;
        logic [SLOT_W-1:0]         slot;
        logic                      slot_ok;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } box_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } back_state_t;

endpackage

// ----- src/aabb_front.sv -----
`timescale 1ns / 1ps
// aabb_front: request intake, action decode and saturated far corners.
// Depends on aabb_pkg; feeds aabb_queue.
module aabb_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [aabb_pkg::SLOT_W-1:0]        slot,
    input  logic signed [aabb_pkg::COORD_W-1:0] left,
    input  logic signed [aabb_pkg::COORD_W-1:0] top,
    input  logic [aabb_pkg::SIZE_W-1:0]        width,
    input  logic [aabb_pkg::SIZE_W-1:0]        height,
    output logic                               push,
    output aabb_pkg::cmd_t                     push_cmd,
    input  logic                               q_full
);

    logic           valid_reg;
    logic           valid_next;
    aabb_pkg::cmd_t cmd_reg;
    aabb_pkg::cmd_t cmd_next;
    logic           accept;
    logic signed [aabb_pkg::COORD_W:0] sum_x;
    logic signed [aabb_pkg::COORD_W:0] sum_y;
    logic signed [aabb_pkg::COORD_W-1:0] far_x;
    logic signed [aabb_pkg::COORD_W-1:0] far_y;

    assign push     = valid_reg && !q_full;
    assign busy     = valid_reg && q_full;
    assign accept   = start && !busy;
    assign push_cmd = cmd_reg;

    // Sum cannot fall below the minimum, so only positive overflow saturates
    always_comb
    begin
        sum_x = $signed({left[aabb_pkg::COORD_W-1], left}) + $signed({2'b00, width});
        sum_y = $signed({top[aabb_pkg::COORD_W-1], top}) + $signed({2'b00, height});
        if (!sum_x[aabb_pkg::COORD_W] && sum_x[aabb_pkg::COORD_W-1])
            far_x = {1'b0, {(aabb_pkg::COORD_W-1){1'b1}}};
        else
            far_x = sum_x[aabb_pkg::COORD_W-1:0];
        if (!sum_y[aabb_pkg::COORD_W] && sum_y[aabb_pkg::COORD_W-1])
            far_y = {1'b0, {(aabb_pkg::COORD_W-1){1'b1}}};
        else
            far_y = sum_y[aabb_pkg::COORD_W-1:0];
    end

    always_comb
    begin
        cmd_next.act     = aabb_pkg::act_t'(action);
        cmd_next.slot    = slot;
        cmd_next.slot_ok = aabb_pkg::SLOT_CMP_W'(slot)
                           < aabb_pkg::SLOT_CMP_W'(aabb_pkg::MAX_BOXES);
        cmd_next.x0      = left;
        cmd_next.y0      = top;
        cmd_next.x1      = far_x;
        cmd_next.y1      = far_y;
        // a point is a degenerate box: the overlap test then becomes containment
        if (aabb_pkg::act_t'(action) == aabb_pkg::ACT_POINT)
        begin
            cmd_next.x1 = left;
            cmd_next.y1 = top;
        end
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

// ----- src/aabb_queue.sv -----
`timescale 1ns / 1ps
// aabb_queue: short request FIFO between front and back.
// Depends on aabb_pkg.
module aabb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aabb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output aabb_pkg::cmd_t head_cmd,
    output logic           empty
);

    aabb_pkg::cmd_t                 data_reg [aabb_pkg::Q_DEPTH];
    logic [aabb_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [aabb_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [aabb_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [aabb_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [aabb_pkg::Q_CNT_W-1:0]   count_reg;
    logic [aabb_pkg::Q_CNT_W-1:0]   count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full     = count_reg == aabb_pkg::Q_CNT_W'(aabb_pkg::Q_DEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = data_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == aabb_pkg::Q_PTR_W'(aabb_pkg::Q_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == aabb_pkg::Q_PTR_W'(aabb_pkg::Q_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- src/aabb_back.sv -----
`timescale 1ns / 1ps
// aabb_back: box table, slot valid bits and the sequential slot scan.
// Depends on aabb_pkg; takes requests from aabb_queue.
module aabb_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  aabb_pkg::cmd_t              head_cmd,
    input  logic                        empty,
    output logic                        pop,
    output logic                        result_strobe,
    output logic [aabb_pkg::SLOT_W-1:0] hit_slot,
    output logic                        found,
    output logic [aabb_pkg::COUNT_W-1:0] hit_count,
    output logic                        last
);

    aabb_pkg::box_t              box_mem [aabb_pkg::MAX_BOXES];
    logic                        slot_valid_reg [aabb_pkg::MAX_BOXES];

    aabb_pkg::back_state_t       state_reg;
    aabb_pkg::back_state_t       state_next;
    aabb_pkg::cmd_t              q_reg;
    aabb_pkg::cmd_t              q_next;
    logic [aabb_pkg::CNT_W-1:0]  rd_cnt_reg;
    logic [aabb_pkg::CNT_W-1:0]  rd_cnt_next;
    logic                        eval_valid_reg;
    logic                        eval_valid_next;
    logic [aabb_pkg::IDX_W-1:0]  eval_idx_reg;
    logic [aabb_pkg::IDX_W-1:0]  eval_idx_next;
    logic [aabb_pkg::COUNT_W-1:0] count_reg;
    logic [aabb_pkg::COUNT_W-1:0] count_next;
    logic [aabb_pkg::IDX_W-1:0]  pend_reg;
    logic [aabb_pkg::IDX_W-1:0]  pend_next;

    aabb_pkg::box_t              rd_box_reg;
    logic                        rd_vld_reg;
    logic                        rd_en;
    logic [aabb_pkg::IDX_W-1:0]  rd_idx;
    logic                        mem_we;
    logic                        vld_we;
    logic                        vld_wdata;
    logic [aabb_pkg::IDX_W-1:0]  wr_idx;
    aabb_pkg::box_t              wr_box;

    logic                        excluded;
    logic                        overlap;
    logic                        eval_hit;
    logic                        eval_last;

    logic                        emit;
    logic [aabb_pkg::IDX_W-1:0]  emit_slot;
    logic                        emit_found;
    logic [aabb_pkg::COUNT_W-1:0] emit_count;
    logic                        emit_last;

    logic                        strobe_reg;
    logic [aabb_pkg::SLOT_W-1:0] hit_slot_reg;
    logic                        found_reg;
    logic [aabb_pkg::COUNT_W-1:0] hit_count_reg;
    logic                        last_reg;

    assign result_strobe = strobe_reg;
    assign hit_slot      = hit_slot_reg;
    assign found         = found_reg;
    assign hit_count     = hit_count_reg;
    assign last          = last_reg;

    // Compare the entry read in the previous cycle against the query box
    assign excluded = (q_reg.act == aabb_pkg::ACT_BOX)
                      && (aabb_pkg::SLOT_CMP_W'(q_reg.slot)
                          == aabb_pkg::SLOT_CMP_W'(eval_idx_reg));
    assign overlap  = ($signed(rd_box_reg.left) < $signed(q_reg.x1))
                      && ($signed(rd_box_reg.right) > $signed(q_reg.x0))
                      && ($signed(rd_box_reg.top) < $signed(q_reg.y1))
                      && ($signed(rd_box_reg.bottom) > $signed(q_reg.y0));
    assign eval_hit  = eval_valid_reg && rd_vld_reg && !excluded && overlap;
    assign eval_last = eval_valid_reg
                       && (eval_idx_reg == aabb_pkg::IDX_W'(aabb_pkg::MAX_BOXES - 1));

    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        rd_cnt_next     = rd_cnt_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = eval_idx_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        vld_we          = 1'b0;
        vld_wdata       = 1'b0;
        wr_idx          = aabb_pkg::IDX_W'(head_cmd.slot);
        wr_box.left     = head_cmd.x0;
        wr_box.top      = head_cmd.y0;
        wr_box.right    = head_cmd.x1;
        wr_box.bottom   = head_cmd.y1;
        rd_en           = 1'b0;
        rd_idx          = rd_cnt_reg[aabb_pkg::IDX_W-1:0];
        emit            = 1'b0;
        emit_slot       = '0;
        emit_found      = 1'b0;
        emit_count      = '0;
        emit_last       = 1'b0;

        unique case (state_reg)
            aabb_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head_cmd.act) inside
                        aabb_pkg::ACT_SET:
                        begin
                            mem_we    = head_cmd.slot_ok;
                            vld_we    = head_cmd.slot_ok;
                            vld_wdata = 1'b1;
                        end
                        aabb_pkg::ACT_REMOVE:
                        begin
                            vld_we    = head_cmd.slot_ok;
                            vld_wdata = 1'b0;
                        end
                        aabb_pkg::ACT_POINT, aabb_pkg::ACT_BOX:
                        begin
                            q_next      = head_cmd;
                            rd_cnt_next = '0;
                            count_next  = '0;
                            state_next  = aabb_pkg::B_SCAN;
                        end
                        default:
                        begin
                            state_next = aabb_pkg::B_IDLE;
                        end
                    endcase
                end
            end
            aabb_pkg::B_SCAN:
            begin
                if (rd_cnt_reg < aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES))
                begin
                    rd_en           = 1'b1;
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                    eval_valid_next = 1'b1;
                    eval_idx_next   = rd_cnt_reg[aabb_pkg::IDX_W-1:0];
                end
                if (eval_hit)
                begin
                    if (q_reg.act == aabb_pkg::ACT_POINT)
                    begin
                        emit       = 1'b1;
                        emit_slot  = eval_idx_reg;
                        emit_found = 1'b1;
                        emit_count = aabb_pkg::COUNT_W'(1);
                        emit_last  = 1'b1;
                        state_next = aabb_pkg::B_IDLE;
                    end
                    else
                    begin
                        // hold each hit back one step so the final one can carry last
                        count_next = count_reg + 1'b1;
                        pend_next  = eval_idx_reg;
                        if (count_reg != '0)
                        begin
                            emit       = 1'b1;
                            emit_slot  = pend_reg;
                            emit_found = 1'b1;
                            emit_count = count_reg;
                        end
                        if (count_next == aabb_pkg::COUNT_W'(aabb_pkg::RESULT_LIMIT))
                            state_next = aabb_pkg::B_DONE;
                    end
                end
                if (eval_last && (state_next == aabb_pkg::B_SCAN))
                    state_next = aabb_pkg::B_DONE;
            end
            aabb_pkg::B_DONE:
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (count_reg != '0)
                begin
                    emit_slot  = pend_reg;
                    emit_found = 1'b1;
                    emit_count = count_reg;
                end
                state_next = aabb_pkg::B_IDLE;
            end
            default:
            begin
                state_next = aabb_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= aabb_pkg::B_IDLE;
            rd_cnt_reg     <= '0;
            eval_valid_reg <= 1'b0;
            count_reg      <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            eval_valid_reg <= eval_valid_next;
            count_reg      <= count_next;
            strobe_reg     <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        eval_idx_reg  <= eval_idx_next;
        pend_reg      <= pend_next;
        hit_slot_reg  <= aabb_pkg::SLOT_W'(emit_slot);
        found_reg     <= emit_found;
        hit_count_reg <= emit_count;
        last_reg      <= emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aabb_pkg::MAX_BOXES; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else if (vld_we)
        begin
            slot_valid_reg[wr_idx] <= vld_wdata;
        end
    end

    // Box table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            box_mem[wr_idx] <= wr_box;
        if (rd_en)
        begin
            rd_box_reg <= box_mem[rd_idx];
            rd_vld_reg <= slot_valid_reg[rd_idx];
        end
    end

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |=> !strobe_reg)
        else $error("result follows directly after a last result");

    a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !found_reg |-> last_reg && (hit_count_reg == '0)
                                     && (hit_slot_reg == '0))
        else $error("not-found result is malformed");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && found_reg |-> (hit_count_reg != '0))
        else $error("hit result with zero count");

endmodule

// ----- src/aabb_collision_table_unit.sv -----
`timescale 1ns / 1ps
// aabb_collision_table_unit: top level of the box collision table.
// Depends on aabb_pkg, aabb_front, aabb_queue and aabb_back.
//
// Usage
//   Request channel: drive action, slot, left, top, width, height with start
//   high; the request is taken at a rising edge where busy is low. Up to three
//   requests may be held (front register plus a two-entry queue) before busy
//   rises, so requests can be issued while a scan is running.
//   Result channel: result_strobe marks hit_slot, found, hit_count and last for
//   exactly one cycle. The receiver cannot stall; results are never held.
//   Set and remove give no result and are done in the idle state, without a scan.
//   A query scans every slot through the single table read port, one slot per
//   cycle, and ends early only when a point query hits. A box query issues
//   each hit one step behind its discovery so the final hit can carry last;
//   on an idle block the request passes the front register, the queue, the
//   scan and the result register before its last result is on the ports.
//   Queries do not overlap on the table side: the next request is popped only
//   after the previous query has issued its last result.
//   Reset clears all slot valid bits and the queue at once; box coordinates
//   are not cleared and are only read behind a set valid bit. No clearing
//   pass is needed, so requests are taken from the first cycle after reset.
module aabb_collision_table_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          action,
    input  logic [aabb_pkg::SLOT_W-1:0]         slot,
    input  logic signed [aabb_pkg::COORD_W-1:0] left,
    input  logic signed [aabb_pkg::COORD_W-1:0] top,
    input  logic [aabb_pkg::SIZE_W-1:0]         width,
    input  logic [aabb_pkg::SIZE_W-1:0]         height,
    output logic                                result_strobe,
    output logic [aabb_pkg::SLOT_W-1:0]         hit_slot,
    output logic                                found,
    output logic [aabb_pkg::COUNT_W-1:0]        hit_count,
    output logic                                last
);

    // front -> queue
    logic           push;
    aabb_pkg::cmd_t push_cmd;
    logic           q_full;

    // queue -> back
    aabb_pkg::cmd_t head_cmd;
    logic           q_empty;
    logic           pop;

    // Decode and far-corner saturation happen once, on intake
    aabb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .slot     (slot),
        .left     (left),
        .top      (top),
        .width    (width),
        .height   (height),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // Lets intake run ahead while the table side is scanning
    aabb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // Table storage, scan sequencer and result register
    aabb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .empty         (q_empty),
        .pop           (pop),
        .result_strobe (result_strobe),
        .hit_slot      (hit_slot),
        .found         (found),
        .hit_count     (hit_count),
        .last          (last)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for aabb_collision_table_unit (set, remove, point and box queries).
// Depends on aabb_pkg and the RTL under src/; reads no files, needs no arguments.
module tb;

    localparam int CLK_HALF_NS   = 6;                     // 12 ns period
    localparam int RANDOM_REQS   = 246;
    localparam int DRAIN_CYCLES  = 3 * (aabb_pkg::MAX_BOXES + 5);
    localparam int WATCHDOG_NS   = 4_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int COORD_MAX     = 32767;
    localparam int COORD_MIN     = -32768;

    // One request as the bench holds it
    typedef struct {
        aabb_pkg::act_t                      act;
        logic [aabb_pkg::SLOT_W-1:0]         slot;
        logic signed [aabb_pkg::COORD_W-1:0] left;
        logic signed [aabb_pkg::COORD_W-1:0] top;
        logic [aabb_pkg::SIZE_W-1:0]         width;
        logic [aabb_pkg::SIZE_W-1:0]         height;
    } box_req_t;

    // One result beat
    typedef struct packed {
        logic [aabb_pkg::SLOT_W-1:0]  hit_slot;
        logic                         found;
        logic [aabb_pkg::COUNT_W-1:0] hit_count;
        logic                         last;
    } hit_report_t;

    logic                                clk    = 1'b0;
    logic                                rst_n  = 1'b0;
    logic                                start  = 1'b0;
    logic [1:0]                          action = 2'd0;
    logic [aabb_pkg::SLOT_W-1:0]         slot   = '0;
    logic signed [aabb_pkg::COORD_W-1:0] left   = '0;
    logic signed [aabb_pkg::COORD_W-1:0] top    = '0;
    logic [aabb_pkg::SIZE_W-1:0]         width  = '0;
    logic [aabb_pkg::SIZE_W-1:0]         height = '0;
    logic                                busy;
    logic                                result_strobe;
    logic [aabb_pkg::SLOT_W-1:0]         hit_slot;
    logic                                found;
    logic [aabb_pkg::COUNT_W-1:0]        hit_count;
    logic                                last;

    // Requests waiting to be driven, and results predicted but not yet seen
    box_req_t    req_backlog [$];
    hit_report_t hits_due [$];
    box_req_t    cur_req;

    // Predicted table contents
    bit tbl_valid  [aabb_pkg::MAX_BOXES];
    int tbl_left   [aabb_pkg::MAX_BOXES];
    int tbl_top    [aabb_pkg::MAX_BOXES];
    int tbl_right  [aabb_pkg::MAX_BOXES];
    int tbl_bottom [aabb_pkg::MAX_BOXES];

    // Shadow of what the generator has set, so queries can aim at real edges
    bit gen_valid  [aabb_pkg::MAX_BOXES];
    int gen_left   [aabb_pkg::MAX_BOXES];
    int gen_top    [aabb_pkg::MAX_BOXES];
    int gen_right  [aabb_pkg::MAX_BOXES];
    int gen_bottom [aabb_pkg::MAX_BOXES];

    int n_total   = 0;    // requests generated
    int n_taken   = 0;    // requests accepted by the block
    int n_errors  = 0;
    int n_results = 0;
    int n_hits    = 0;
    int n_act [4] = '{0, 0, 0, 0};

    int unsigned idle_left  = 0;
    int unsigned quiet_left = 0;

    aabb_collision_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .slot          (slot),
        .left          (left),
        .top           (top),
        .width         (width),
        .height        (height),
        .result_strobe (result_strobe),
        .hit_slot      (hit_slot),
        .found         (found),
        .hit_count     (hit_count),
        .last          (last)
    );

    initial
    begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Far corner: near edge plus size, clipped at the top of the signed range
    function automatic int far_corner(int near_edge, int size);
        int s;
        s = near_edge + size;
        return (s > COORD_MAX) ? COORD_MAX : s;
    endfunction

    function automatic hit_report_t make_hit(int idx, bit hit, int cnt, bit fin);
        hit_report_t h;
        h.hit_slot  = aabb_pkg::SLOT_W'(idx);
        h.found     = hit;
        h.hit_count = aabb_pkg::COUNT_W'(cnt);
        h.last      = fin;
        return h;
    endfunction

    // Apply one accepted request to the predicted table and queue its results.
    // Queries read the table as it stands after every earlier request.
    function automatic void predict_table_op(box_req_t r);
        int x0;
        int y0;
        int x1;
        int y1;
        int slot_hits [$];
        x0 = int'(r.left);
        y0 = int'(r.top);
        x1 = far_corner(x0, int'(r.width));
        y1 = far_corner(y0, int'(r.height));
        n_act[r.act]++;
        case (r.act)
            aabb_pkg::ACT_SET:
            begin
                tbl_valid[r.slot]  = 1'b1;
                tbl_left[r.slot]   = x0;
                tbl_top[r.slot]    = y0;
                tbl_right[r.slot]  = x1;
                tbl_bottom[r.slot] = y1;
            end
            aabb_pkg::ACT_REMOVE:
                tbl_valid[r.slot] = 1'b0;
            aabb_pkg::ACT_POINT:
            begin
                // lowest valid slot strictly containing the point; edges do not count
                for (int i = 0; i < aabb_pkg::MAX_BOXES && slot_hits.size() == 0; i++)
                    if (tbl_valid[i] && tbl_left[i] < x0 && tbl_right[i] > x0 &&
                        tbl_top[i] < y0 && tbl_bottom[i] > y0)
                        slot_hits.insert(slot_hits.size(), i);
                if (slot_hits.size() != 0)
                    hits_due.insert(hits_due.size(), make_hit(slot_hits[0], 1'b1, 1, 1'b1));
            end
            aabb_pkg::ACT_BOX:
            begin
                // every valid slot but the named one that strictly overlaps
                for (int i = 0; i < aabb_pkg::MAX_BOXES &&
                     slot_hits.size() < aabb_pkg::RESULT_LIMIT; i++)
                    if (tbl_valid[i] && i != int'(r.slot) &&
                        tbl_left[i] < x1 && tbl_right[i] > x0 &&
                        tbl_top[i] < y1 && tbl_bottom[i] > y0)
                        slot_hits.insert(slot_hits.size(), i);
                foreach (slot_hits[k])
                    hits_due.insert(hits_due.size(),
                                    make_hit(slot_hits[k], 1'b1, k + 1,
                                             k == slot_hits.size() - 1));
            end
        endcase
        // a query that finds nothing still gives one closing result
        if ((r.act == aabb_pkg::ACT_POINT || r.act == aabb_pkg::ACT_BOX)
            && slot_hits.size() == 0)
            hits_due.insert(hits_due.size(), make_hit(0, 1'b0, 0, 1'b1));
        n_hits += slot_hits.size();
    endfunction

    // Queue a request for the driver and track what the table will hold
    function automatic void queue_req(aabb_pkg::act_t a, int s, int l, int t, int w, int h);
        box_req_t r;
        r.act    = a;
        r.slot   = aabb_pkg::SLOT_W'(s);
        r.left   = aabb_pkg::COORD_W'(l);
        r.top    = aabb_pkg::COORD_W'(t);
        r.width  = aabb_pkg::SIZE_W'(w);
        r.height = aabb_pkg::SIZE_W'(h);
        req_backlog.insert(req_backlog.size(), r);
        n_total++;
        if (a == aabb_pkg::ACT_SET)
        begin
            gen_valid[r.slot]  = 1'b1;
            gen_left[r.slot]   = int'(r.left);
            gen_top[r.slot]    = int'(r.top);
            gen_right[r.slot]  = far_corner(int'(r.left), int'(r.width));
            gen_bottom[r.slot] = far_corner(int'(r.top), int'(r.height));
        end
        else if (a == aabb_pkg::ACT_REMOVE)
            gen_valid[r.slot] = 1'b0;
    endfunction

    // Mostly a small window round the origin so boxes collide; now and then anything
    function automatic int pick_coord();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 65535)) + COORD_MIN;
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 2047);
        return $urandom_range(0, 32767);
    endfunction

    // On, just inside or in the middle of an edge pair: where strictness matters
    function automatic int near_edge(int lo, int hi);
        int v;
        case ($urandom_range(0, 4))
            0:       v = lo;
            1:       v = hi;
            2:       v = lo + 1;
            3:       v = hi - 1;
            default: v = (lo + hi) / 2;
        endcase
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    // Request driver: holds start with the fields until taken (start high, busy low),
    // then waits a drawn number of idle cycles. Now and then a run of back-to-back
    // requests keeps the front register and queue full so busy gets exercised.
    always @(posedge clk or negedge rst_n)
    begin
        box_req_t    nxt;
        int unsigned hold;
        logic        drive;
        if (!rst_n)
        begin
            start      <= 1'b0;
            action     <= aabb_pkg::ACT_SET;
            slot       <= '0;
            left       <= '0;
            top        <= '0;
            width      <= '0;
            height     <= '0;
            idle_left  <= 0;
            quiet_left <= 0;
        end
        else
        begin
            drive = start;
            hold  = idle_left;
            if (start && !busy)
            begin
                predict_table_op(cur_req);
                n_taken++;
                drive = 1'b0;
                if (quiet_left > 0)
                begin
                    hold = 0;
                    quiet_left <= quiet_left - 1;
                end
                else
                begin
                    hold = $urandom_range(0, 17);
                    if ($urandom_range(0, 15) == 0)
                        quiet_left <= $urandom_range(8, 30);
                end
            end
            else if (!drive && hold > 0)
                hold--;
            // a request taken with no idle drawn is followed at once: start stays high
            if (!drive && hold == 0 && req_backlog.size() > 0)
            begin
                nxt = req_backlog.pop_front();
                cur_req <= nxt;
                action  <= nxt.act;
                slot    <= nxt.slot;
                left    <= nxt.left;
                top     <= nxt.top;
                width   <= nxt.width;
                height  <= nxt.height;
                drive   = 1'b1;
            end
            start     <= drive;
            idle_left <= hold;
        end
    end

    // Result monitor: the block cannot be held off, so every strobe is a result
    always @(posedge clk)
    begin
        hit_report_t want;
        hit_report_t got;
        if (rst_n && result_strobe)
        begin
            n_results++;
            got = '{hit_slot, found, hit_count, last};
            if (hits_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result slot=%0d found=%0b count=%0d last=%0b",
                             $realtime, got.hit_slot, got.found, got.hit_count, got.last);
            end
            else
            begin
                want = hits_due.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"%0t: result mismatch: expected slot=%0d found=%0b ",
                                  "count=%0d last=%0b, got slot=%0d found=%0b count=%0d ",
                                  "last=%0b"}, $realtime,
                                 want.hit_slot, want.found, want.hit_count, want.last,
                                 got.hit_slot, got.found, got.hit_count, got.last);
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int r;
        int s;
        int px;
        int py;
        int directed_n;

        // Directed: empty table, range extremes, saturation, touching edges,
        // a zero-size box, removal (twice) and the excluded slot of a box query.
        queue_req(aabb_pkg::ACT_POINT,  0, 0, 0, 0, 0);
        queue_req(aabb_pkg::ACT_BOX,    0, COORD_MIN, COORD_MIN, 32767, 32767);
        queue_req(aabb_pkg::ACT_SET,    0, COORD_MIN, COORD_MIN, 32767, 32767); // far -1,-1
        queue_req(aabb_pkg::ACT_SET,   31, 28672, 28672, 32767, 32767);         // saturates
        queue_req(aabb_pkg::ACT_SET,    5, 0, 0, 160, 160);
        queue_req(aabb_pkg::ACT_SET,    6, 160, 0, 160, 160);                   // touches 5
        queue_req(aabb_pkg::ACT_SET,    7, 20, 20, 0, 0);                       // zero size
        queue_req(aabb_pkg::ACT_POINT,  0, 80, 80, 32767, 0);
        queue_req(aabb_pkg::ACT_POINT,  0, 160, 80, 0, 32767);                  // shared edge
        queue_req(aabb_pkg::ACT_POINT,  0, -100, -100, 0, 0);
        queue_req(aabb_pkg::ACT_POINT,  0, 32766, 32766, 0, 0);
        queue_req(aabb_pkg::ACT_POINT,  0, COORD_MAX, COORD_MAX, 0, 0);         // clipped edge
        queue_req(aabb_pkg::ACT_POINT,  0, COORD_MIN, COORD_MIN, 0, 0);
        queue_req(aabb_pkg::ACT_BOX,    6, -100, -100, 32767, 32767);
        queue_req(aabb_pkg::ACT_BOX,   31, 0, 0, 160, 160);
        queue_req(aabb_pkg::ACT_BOX,    5, 160, 0, 0, 160);                     // zero width
        queue_req(aabb_pkg::ACT_BOX,    0, COORD_MAX, COORD_MAX, 32767, 32767);
        queue_req(aabb_pkg::ACT_REMOVE, 5, 0, 0, 0, 0);
        queue_req(aabb_pkg::ACT_POINT,  0, 80, 80, 0, 0);
        queue_req(aabb_pkg::ACT_REMOVE, 5, -1, -1, 32767, 32767);               // already empty
        queue_req(aabb_pkg::ACT_SET,    5, -1, -1, 32767, 32767);
        queue_req(aabb_pkg::ACT_BOX,   17, COORD_MIN, COORD_MAX, 32767, 0);
        queue_req(aabb_pkg::ACT_REMOVE, 0, 0, 0, 0, 0);
        queue_req(aabb_pkg::ACT_REMOVE, 31, 0, 0, 0, 0);
        directed_n = n_total;

        // Random part. Occasionally every slot is filled with a box round the
        // origin and then queried, so long runs of hits and high counts occur.
        while (n_total < directed_n + RANDOM_REQS)
        begin
            if (n_total == directed_n || $urandom_range(0, 59) == 0)
            begin
                for (int i = 0; i < aabb_pkg::MAX_BOXES; i++)
                begin
                    px = $urandom_range(1, 3000);
                    py = $urandom_range(1, 3000);
                    queue_req(aabb_pkg::ACT_SET, i, -px, -py,
                              px + $urandom_range(1, 3000), py + $urandom_range(1, 3000));
                end
                queue_req(aabb_pkg::ACT_BOX, $urandom_range(0, 31), -10, -10, 20, 20);
                queue_req(aabb_pkg::ACT_POINT, $urandom_range(0, 31), 0, 0,
                          pick_size(), pick_size());
                continue;
            end
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 31);
            if (r < 35)
                queue_req(aabb_pkg::ACT_SET, s, pick_coord(), pick_coord(),
                          pick_size(), pick_size());
            else if (r < 45)
                queue_req(aabb_pkg::ACT_REMOVE, s, pick_coord(), pick_coord(),
                          $urandom_range(0, 32767), $urandom_range(0, 32767));
            else if (r < 72)
            begin
                if (gen_valid[s] && $urandom_range(0, 2) != 0)
                begin
                    px = near_edge(gen_left[s], gen_right[s]);
                    py = near_edge(gen_top[s], gen_bottom[s]);
                end
                else
                begin
                    px = pick_coord();
                    py = pick_coord();
                end
                queue_req(aabb_pkg::ACT_POINT, $urandom_range(0, 31), px, py,
                          $urandom_range(0, 32767), $urandom_range(0, 32767));
            end
            else
                queue_req(aabb_pkg::ACT_BOX, s, pick_coord(), pick_coord(),
                          pick_size(), pick_size());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (n_taken != n_total)
            @(posedge clk);
        while (hits_due.size() != 0)
            @(posedge clk);
        // set/remove requests still in the block give nothing; let them drain and
        // catch anything spurious
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d sets, %0d removes, %0d point and %0d box queries.",
                 n_taken, n_act[aabb_pkg::ACT_SET], n_act[aabb_pkg::ACT_REMOVE],
                 n_act[aabb_pkg::ACT_POINT], n_act[aabb_pkg::ACT_BOX]);
        $display("Checked %0d results (%0d hits); %0d mismatches, %0d results missing.",
                 n_results, n_hits, n_errors, hits_due.size());
        if (n_errors == 0 && hits_due.size() == 0)
            $display("** aabb_collision_table_unit: PASSED **");
        else
            $display("** aabb_collision_table_unit: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timeout: %0d of %0d requests taken, %0d results outstanding.",
                 n_taken, n_total, hits_due.size());
        $display("** aabb_collision_table_unit: FAILED **");
        $finish;
    end

endmodule

// ----- aabb_collision_table_unit.f -----
src/aabb_pkg.sv
src/aabb_front.sv
src/aabb_queue.sv
src/aabb_back.sv
src/aabb_collision_table_unit.sv
tb/tb.sv
